// ===== src/hid_report_id_extractor_macros.svh =====
// Assertion macros for the RTL file hid_report_id_extractor.sv.
`ifndef HID_REPORT_ID_EXTRACTOR_MACROS_SVH
`define HID_REPORT_ID_EXTRACTOR_MACROS_SVH

`ifndef ASSERT_OFF

`define HRID_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

`define HRID_ASSERT_IMPL(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

`else

`define HRID_ASSERT(lbl, clk_sig, rst_sig, prop, msg)

`define HRID_ASSERT_IMPL(lbl, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

// ===== src/hid_rid_pkg.sv =====
package hid_rid_pkg;

  localparam logic [1:0] ITEM_TYPE_GLOBAL = 2'h1;
  localparam logic [3:0] TAG_REPORT_ID    = 4'h8;
  localparam logic [1:0] SIZE_CODE_FOUR   = 2'h3;
  localparam logic [4:0] MAX_IDS_RESET    = 5'd16;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN    = 4'b0010,
    ST_EMIT_RD = 4'b0100,
    ST_EMIT_LD = 4'b1000
  } seq_state_t;

endpackage

// ===== src/hid_report_id_extractor.sv =====
// Flow: each descriptor byte is taken in ST_IDLE; a Report ID data byte taken below the ID limit
//   is then scanned in ST_SCAN, one table entry compared per cycle on the table read port.
// No new byte is taken until the scan ends (s_axis_tready is high only in ST_IDLE); on the
//   last byte each result is read (ST_EMIT_RD), then loaded (ST_EMIT_LD) once the sink has room.
// Reset: synchronous on rst; parser state and ID count clear, max_ids becomes 16,
//   the ID table holds no valid entries and is never cleared.
`include "hid_report_id_extractor_macros.svh"

module hid_report_id_extractor #(
  parameter int MAX_REPORT_IDS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [4:0]                          cfg_wr_data,   // max_ids
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [hid_rid_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] desc_byte
  input  logic                                s_axis_tlast,  // last_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] rep_id, [11:8] id_index, [16:12] id_count, [23:17] zero
  output logic [hid_rid_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                                m_axis_tlast   // last_id
);
  import hid_rid_pkg::*;

  localparam int CW = $clog2(MAX_REPORT_IDS + 1);
  localparam int AW = (MAX_REPORT_IDS > 1) ? $clog2(MAX_REPORT_IDS) : 1;
  localparam int LW = (CW > 5) ? CW : 5;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_REPORT_IDS);

  seq_state_t    state;
  logic [4:0]    max_ids;
  logic [2:0]    bytes_to_skip;
  logic          id_pending;
  logic [CW-1:0] found_count;
  logic [CW-1:0] ptr;
  logic          cmp_pending;
  logic          last_pend;
  logic [7:0]    cand;
  logic [7:0]    rd_data;
  logic [7:0]    id_table [MAX_REPORT_IDS];

  logic [7:0]    rep_id_q;
  logic [3:0]    id_index_q;
  logic [4:0]    id_count_q;
  logic          last_id_q;

  logic          in_xfer;
  logic [LW-1:0] lim;
  logic          at_limit;
  logic [1:0]    size_code;
  logic [2:0]    size;
  logic          scan_hit;
  logic          scan_more;
  logic          tbl_we;
  logic [CW:0]   ptr_inc;
  logic          out_free;
  logic          last_idx_ok;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Clamp the limit to the table depth.
  assign lim      = (LW'(max_ids) > MAX_L) ? MAX_L : LW'(max_ids);
  assign at_limit = LW'(found_count) >= lim;

  assign size_code = s_axis_tdata[1:0];
  assign size      = (size_code == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, size_code};

  assign scan_hit  = cmp_pending && (rd_data == cand);
  assign scan_more = ptr < found_count;
  assign tbl_we    = (state == ST_SCAN) && !scan_hit && !scan_more &&
                     (LW'(found_count) < MAX_L);
  assign ptr_inc   = {1'b0, ptr} + 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // ID table: one write port, one registered read port shared by scan and emit.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      id_table[found_count[AW-1:0]] <= cand;
    end
    rd_data <= id_table[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      max_ids       <= MAX_IDS_RESET;
      bytes_to_skip <= '0;
      id_pending    <= 1'b0;
      found_count   <= '0;
      ptr           <= '0;
      cmp_pending   <= 1'b0;
      last_pend     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_ids <= cfg_wr_data;
      end
      // the emit load state owns valid while it is active
      if (m_axis_tready && state != ST_EMIT_LD) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            priority if (!at_limit && bytes_to_skip == 3'd0) begin
              bytes_to_skip <= size;
              id_pending    <= (s_axis_tdata[3:2] == ITEM_TYPE_GLOBAL) &&
                               (s_axis_tdata[7:4] == TAG_REPORT_ID) && (size != 3'd0);
            end else if (!at_limit) begin
              bytes_to_skip <= bytes_to_skip - 3'd1;
              id_pending    <= 1'b0;
            end else begin
              // ID limit reached: drop the byte
            end
            last_pend   <= s_axis_tlast;
            ptr         <= '0;
            cmp_pending <= 1'b0;
            if (!at_limit && bytes_to_skip != 3'd0 && id_pending) begin
              cand  <= s_axis_tdata[7:0];
              state <= ST_SCAN;
            end else if (s_axis_tlast) begin
              state <= ST_EMIT_RD;
            end
          end
        end

        ST_SCAN: begin
          priority if (scan_hit || !scan_more) begin
            if (tbl_we) begin
              found_count <= found_count + 1'b1;
            end
            ptr         <= '0;
            cmp_pending <= 1'b0;
            state       <= last_pend ? ST_EMIT_RD : ST_IDLE;
          end else begin
            // advance: compare this entry next cycle
            ptr         <= ptr_inc[CW-1:0];
            cmp_pending <= 1'b1;
          end
        end

        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end

        ST_EMIT_LD: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            if (found_count == '0) begin
              rep_id_q    <= 8'd0;
              id_index_q  <= 4'd0;
              id_count_q  <= 5'd1;
              last_id_q   <= 1'b1;
            end else begin
              rep_id_q    <= rd_data;
              id_index_q  <= 4'(ptr);
              id_count_q  <= 5'(found_count);
              last_id_q   <= (ptr_inc == {1'b0, found_count});
            end
            if (found_count == '0 || ptr_inc == {1'b0, found_count}) begin
              found_count   <= '0;
              bytes_to_skip <= '0;
              id_pending    <= 1'b0;
              ptr           <= '0;
              state         <= ST_IDLE;
            end else begin
              ptr   <= ptr_inc[CW-1:0];
              state <= ST_EMIT_RD;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, id_count_q, id_index_q, rep_id_q};
  assign m_axis_tlast = last_id_q;

  assign last_idx_ok = (({1'b0, id_index_q} + 5'd1) == id_count_q);

  `HRID_ASSERT(a_count_bound, clk, rst, LW'(found_count) <= MAX_L, "ID count above depth")
  `HRID_ASSERT_IMPL(a_load, clk, rst, $rose(m_axis_tvalid), $past(state) == ST_EMIT_LD, "stray load")
  `HRID_ASSERT_IMPL(a_last_idx, clk, rst, m_axis_tvalid && m_axis_tlast, last_idx_ok, "last index")

endmodule

// ===== tb/sv/tb_hid_report_id_extractor.sv =====
`timescale 1ns / 1ps

module tb_hid_report_id_extractor;
  import hid_rid_pkg::*;

  localparam int TABLE_DEPTH = 16;

  typedef struct {
    logic [7:0] rep_id;
    logic [3:0] id_index;
    logic [4:0] id_count;
    logic       last_id;
  } id_result_t;

  typedef struct {
    logic [7:0] desc_byte;
    bit         fin;
    bit         typed;
    logic [7:0] typed_id;
  } desc_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_SPARSE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [4:0]            cfg_wr_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] desc_byte
  logic                  s_axis_tlast = 1'b0; // last_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [7:0] rep_id, [11:8] id_index, [16:12] id_count, [23:17] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;        // last_id

  // scoreboard-side copy of the parser
  logic [4:0] id_limit;
  logic [2:0] skip_left;
  logic       id_next;
  logic [4:0] n_found;
  logic [7:0] found_ids [TABLE_DEPTH];

  id_result_t pending_ids [$];
  int         mismatch_count = 0;
  int         burst_left = 0;
  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_phase_left = 0;
  int         rx_tick = 0;

  logic [7:0] id_pool [4] = '{8'h00, 8'h01, 8'h7F, 8'hFF};
  logic [4:0] limit_plan [8] = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd5, 5'd17, 5'd2, 5'd16};

  desc_row_t directed_rows [24] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00},  // empty descriptor
    '{8'h85, 1'b1, 1'b1, 8'h00},  // Report ID header cut off by the last byte
    '{8'h85, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h85, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
    '{8'h85, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},  // duplicate
    '{8'h86, 1'b0, 1'b0, 8'h00}, '{8'h07, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h87, 1'b0, 1'b0, 8'h00}, '{8'h10, 1'b0, 1'b0, 8'h00},
    '{8'h20, 1'b0, 1'b0, 8'h00}, '{8'h30, 1'b0, 1'b0, 8'h00},
    '{8'h40, 1'b0, 1'b0, 8'h00},
    '{8'h84, 1'b0, 1'b0, 8'h00},  // Report ID with no data
    '{8'h95, 1'b0, 1'b0, 8'h00}, '{8'h42, 1'b0, 1'b0, 8'h00},
    '{8'h81, 1'b0, 1'b0, 8'h00}, '{8'h55, 1'b0, 1'b0, 8'h00},
    '{8'hC0, 1'b1, 1'b0, 8'h00},
    '{8'h87, 1'b0, 1'b0, 8'h00}, '{8'h21, 1'b1, 1'b1, 8'h21}  // data cut off
  };

  always #5 clk = ~clk;

  hid_report_id_extractor #(
    .MAX_REPORT_IDS(TABLE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic void absorb_desc_byte(input logic [7:0] b, input bit fin,
                                           ref id_result_t res_q [$]);
    int         lim;
    int         size;
    bit         dup;
    id_result_t r;
    lim = (id_limit > TABLE_DEPTH) ? TABLE_DEPTH : id_limit;
    if (n_found < lim) begin
      if (skip_left == 0) begin
        size = (b[1:0] == SIZE_CODE_FOUR) ? 4 : b[1:0];
        skip_left = size[2:0];
        id_next = (b[3:2] == ITEM_TYPE_GLOBAL) && (b[7:4] == TAG_REPORT_ID) && (size >= 1);
      end else begin
        if (id_next) begin
          dup = 1'b0;
          for (int k = 0; k < n_found; k++)
            if (found_ids[k] == b) dup = 1'b1;
          if (!dup && n_found < TABLE_DEPTH) begin
            found_ids[n_found[3:0]] = b;
            n_found++;
          end
        end
        id_next = 1'b0;
        skip_left--;
      end
    end
    if (fin) begin
      if (n_found == 0) begin
        res_q.push_back('{8'h00, 4'd0, 5'd1, 1'b1});
      end else begin
        for (int k = 0; k < n_found; k++) begin
          r.rep_id    = found_ids[k];
          r.id_index  = k[3:0];
          r.id_count  = n_found;
          r.last_id   = (k + 1 == n_found);
          res_q.push_back(r);
        end
      end
      skip_left = '0;
      id_next   = 1'b0;
      n_found   = '0;
    end
  endfunction

  // Hold the byte until the transfer, record what it causes, then maybe idle.
  task automatic send_byte(input logic [7:0] b, input bit fin, input bit typed,
                           input logic [7:0] typed_id);
    id_result_t caused [$];
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    absorb_desc_byte(b, fin, caused);
    if (typed) pending_ids.push_back('{typed_id, 4'd0, 5'd1, 1'b1});
    else pending_ids = {pending_ids, caused};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
    end
  endtask

  // Drop valid and wait until every expected ID is out and the parser is quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_ids.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_limit(input logic [4:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    id_limit = v;
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed items, Report ID items at id_pct percent, some noise bytes.
  task automatic send_descriptor(input int n_bytes, input int id_pct);
    logic [7:0] desc [$];
    logic [7:0] hdr;
    logic [1:0] code;
    int         pick;
    int         size;
    while (desc.size() < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < id_pct) begin
        code = 2'($urandom_range(1, 3));
        size = (code == SIZE_CODE_FOUR) ? 4 : code;
        desc.push_back({TAG_REPORT_ID, ITEM_TYPE_GLOBAL, code});
        desc.push_back(($urandom_range(0, 2) == 0) ? id_pool[$urandom_range(0, 3)]
                                                   : 8'($urandom_range(0, 255)));
        repeat (size - 1) desc.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        hdr  = 8'($urandom_range(0, 255));
        size = (hdr[1:0] == SIZE_CODE_FOUR) ? 4 : hdr[1:0];
        desc.push_back(hdr);
        repeat (size) desc.push_back(8'($urandom_range(0, 255)));
      end else begin
        desc.push_back(8'($urandom_range(0, 255)));
      end
    end
    // cut the tail sometimes so the last byte lands inside an item
    if ($urandom_range(0, 3) == 0 && desc.size() > 3) begin
      repeat ($urandom_range(1, 2)) void'(desc.pop_back());
    end
    foreach (desc[i]) send_byte(desc[i], i == desc.size() - 1, 1'b0, 8'h00);
  endtask

  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(20, 80);
    end
    rx_phase_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
      RX_THIRD: m_axis_tready <= (rx_tick % 3 == 0);
      default:  m_axis_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin
    id_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_ids.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected ID transfer, expected none, got tdata=%h tlast=%b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_ids.pop_front();
        if (m_axis_tdata[7:0] !== want.rep_id || m_axis_tdata[11:8] !== want.id_index ||
            m_axis_tdata[16:12] !== want.id_count || m_axis_tlast !== want.last_id ||
            m_axis_tdata[OUT_DATA_W-1:17] !== '0) begin
          mismatch_count++;
          $display("%0t: expected id=%h idx=%0d cnt=%0d last=%b pad=0,",
                   $time, want.rep_id, want.id_index, want.id_count, want.last_id,
                   " got id=%h idx=%0d cnt=%0d last=%b pad=%h",
                   m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tdata[16:12],
                   m_axis_tlast, m_axis_tdata[OUT_DATA_W-1:17]);
        end
      end
    end
  end

  initial begin
    id_limit  = MAX_IDS_RESET;
    skip_left = '0;
    id_next   = 1'b0;
    n_found   = '0;
    limit_plan[6] = 5'($urandom_range(1, 15));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_byte(directed_rows[i].desc_byte, directed_rows[i].fin,
                directed_rows[i].typed, directed_rows[i].typed_id);
    settle();
    foreach (limit_plan[p]) begin
      write_limit(limit_plan[p]);
      send_descriptor($urandom_range(6, 16), 45);
      // push the table to its limit
      if (limit_plan[p] == 5'd31) send_descriptor(72, 95);
      settle();
    end
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
